// ----- rtl/shifted_table_linear_interpolator_defines.svh -----
// Assertion helpers for the shifted table interpolator.
`ifndef SHIFTED_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define SHIFTED_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define STLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/stli_pkg.sv -----
package stli_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

	localparam logic [1:0] REG_SCALE   = 2'd0;
	localparam logic [1:0] REG_SHIFT   = 2'd1;
	localparam logic [1:0] REG_ENTRIES = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_CMP,
		ST_READL,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_MIX,
		ST_SCALE,
		ST_SAT
	} state_t;

	typedef struct packed {
		logic wr;
		logic cap_query;
		logic zero_y;
		logic ptr_inc;
		logic cap_right;
		logic hit_y;
		logic rd_left;
		logic load_left;
		logic div_step;
		logic mul;
		logic mix;
		logic scale;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic go_scan;
		logic advance;
		logic hit;
		logic inner;
		logic need_div;
		logic div_done;
		logic out_free;
		logic ptr_zero;
		logic last_pend;
	} stat_t;

endpackage

// ----- rtl/stli_ctrl.sv -----
module stli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	input  stli_pkg::stat_t st,
	output stli_pkg::cmd_t  cmd,
	output logic            busy
);

	stli_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stli_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = (state_q != stli_pkg::ST_IDLE);
		case (state_q)
			stli_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (action) begin
						cmd.cap_query = 1'b1;
						state_nx      = stli_pkg::ST_CHECK;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			stli_pkg::ST_CHECK: begin
				if (st.go_scan) begin
					state_nx = stli_pkg::ST_READ;
				end else begin
					cmd.zero_y = 1'b1;
					state_nx   = stli_pkg::ST_SCALE;
				end
			end
			stli_pkg::ST_READ: begin
				state_nx = stli_pkg::ST_CMP;
			end
			stli_pkg::ST_CMP: begin
				if (st.advance) begin
					cmd.ptr_inc = 1'b1;
					state_nx    = stli_pkg::ST_READ;
				end else begin
					cmd.cap_right = 1'b1;
					if (st.hit) begin
						cmd.hit_y = 1'b1;
						state_nx  = stli_pkg::ST_SCALE;
					end else if (st.inner) begin
						state_nx = stli_pkg::ST_READL;
					end else begin
						cmd.zero_y = 1'b1;
						state_nx   = stli_pkg::ST_SCALE;
					end
				end
			end
			stli_pkg::ST_READL: begin
				cmd.rd_left = 1'b1;
				state_nx    = stli_pkg::ST_LOAD;
			end
			stli_pkg::ST_LOAD: begin
				cmd.load_left = 1'b1;
				state_nx = st.need_div ? stli_pkg::ST_DIV : stli_pkg::ST_SCALE;
			end
			stli_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					state_nx = stli_pkg::ST_MUL;
				end
			end
			stli_pkg::ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = stli_pkg::ST_MIX;
			end
			stli_pkg::ST_MIX: begin
				cmd.mix  = 1'b1;
				state_nx = stli_pkg::ST_SCALE;
			end
			stli_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = stli_pkg::ST_SAT;
			end
			stli_pkg::ST_SAT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_nx = stli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = stli_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/stli_dp.sv -----
module stli_dp #(
	parameter int TABLE_DEPTH = stli_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [7:0]         entry_index,
	input  logic signed [31:0] entry_x,
	input  logic signed [31:0] entry_y,
	input  logic signed [31:0] query_x,
	input  logic               last_query,
	input  stli_pkg::cmd_t     cmd,
	output stli_pkg::stat_t    st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               saturated,
	output logic               last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic signed [65:0] MAXV = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] MINV = -66'sh0_8000_0000;

	logic [31:0] scale_q, shift_q;
	logic [8:0]  entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= stli_pkg::SCALE_RESET;
			shift_q   <= '0;
			entries_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stli_pkg::REG_SCALE:   scale_q   <= cfg_data;
				stli_pkg::REG_SHIFT:   shift_q   <= cfg_data;
				stli_pkg::REG_ENTRIES: entries_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Table memory: one write port, one registered read port.
	logic [31:0] mem_x [TABLE_DEPTH];
	logic [31:0] mem_y [TABLE_DEPTH];
	logic [31:0] rd_x_s1, rd_y_s1;
	logic [AW-1:0] ptr_q, raddr;

	assign raddr = cmd.rd_left ? ptr_q - AW'(1) : ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.wr && (32'(entry_index) < 32'(TABLE_DEPTH))) begin
			mem_x[AW'(entry_index)] <= entry_x;
			mem_y[AW'(entry_index)] <= entry_y;
		end
		rd_x_s1 <= mem_x[raddr];
		rd_y_s1 <= mem_y[raddr];
	end

	// Effective point count and pointer compares.
	logic [31:0] n_eff, ptr_ext;
	assign n_eff   = (32'(entries_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(entries_q);
	assign ptr_ext = 32'(ptr_q);

	logic signed [31:0] q_q;
	logic               last_q;
	logic signed [33:0] q34, sx, x1_q;
	logic signed [31:0] y1_q, y0_q;
	logic signed [35:0] num, den;

	assign q34 = 34'(q_q);
	assign sx  = 34'($signed(rd_x_s1)) + 34'($signed(shift_q));
	assign num = 36'(q34) - 36'(sx);
	assign den = 36'(x1_q) - 36'(sx);

	logic [35:0] rem_q, r2;
	logic [34:0] den_q;
	logic [31:0] f_q;
	logic [4:0]  cnt_q;
	logic signed [33:0] yv_q;
	logic signed [49:0] a_s1, b_s1;
	logic signed [32:0] dy;
	logic signed [50:0] mixsum;
	logic signed [65:0] prod_q, p;

	assign r2     = {rem_q[34:0], 1'b0};
	assign dy     = 33'(y1_q) - 33'(y0_q);
	assign mixsum = 51'(a_s1) + 51'(b_s1 >>> 16);
	assign p      = prod_q >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.emit && last_q) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			q_q    <= query_x;
			last_q <= last_query;
		end
		if (cmd.cap_right) begin
			x1_q <= sx;
			y1_q <= $signed(rd_y_s1);
		end
		if (cmd.zero_y) begin
			yv_q <= '0;
		end
		if (cmd.hit_y) begin
			yv_q <= 34'($signed(rd_y_s1));
		end
		if (cmd.load_left) begin
			y0_q  <= $signed(rd_y_s1);
			rem_q <= num;
			den_q <= den[34:0];
			f_q   <= '0;
			cnt_q <= '0;
			if (den <= 0 || num <= 0) begin
				yv_q <= 34'($signed(rd_y_s1));
			end else if (num >= den) begin
				yv_q <= 34'(y1_q);
			end
		end
		if (cmd.div_step) begin
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= r2 - {1'b0, den_q};
				f_q   <= {f_q[30:0], 1'b1};
			end else begin
				rem_q <= r2;
				f_q   <= {f_q[30:0], 1'b0};
			end
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.mul) begin
			a_s1 <= 50'(dy) * 50'($signed({1'b0, f_q[31:16]}));
			b_s1 <= 50'(dy) * 50'($signed({1'b0, f_q[15:0]}));
		end
		if (cmd.mix) begin
			yv_q <= 34'(y0_q) + 34'(mixsum >>> 16);
		end
		if (cmd.scale) begin
			prod_q <= 66'(yv_q) * 66'($signed(scale_q));
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last <= last_q;
			if (p > MAXV) begin
				value     <= 32'sh7FFF_FFFF;
				saturated <= 1'b1;
			end else if (p < MINV) begin
				value     <= 32'sh8000_0000;
				saturated <= 1'b1;
			end else begin
				value     <= p[31:0];
				saturated <= 1'b0;
			end
		end
	end

	assign st.go_scan   = (n_eff >= 32'd2) && (ptr_ext + 32'd1 < n_eff);
	assign st.advance   = (ptr_ext + 32'd1 < n_eff) && (q34 > sx);
	assign st.hit       = (q34 == sx);
	assign st.inner     = (ptr_ext + 32'd1 != n_eff) && (ptr_q != '0);
	assign st.need_div  = !(den <= 0 || num <= 0 || num >= den);
	assign st.div_done  = (cnt_q == 5'd31);
	assign st.out_free  = !out_valid || !out_stall;
	assign st.ptr_zero  = (ptr_q == '0);
	assign st.last_pend = last_q;

endmodule

// ----- rtl/shifted_table_linear_interpolator.sv -----
// Shifted-table piecewise linear interpolator. A write transaction (action 0) stores one
// (x, y) point in the table; it gives no result. A query transaction
// (action 1) gives exactly one result transaction: the ordinate scaled by the scale register
// on an exact hit of the shifted abscissa x + shift, a scaled linear interpolation inside a
// segment, or zero before the first point, past the last point, with fewer than two points,
// or once the segment pointer has reached the last point. Queries in a batch should ascend;
// the pointer only moves forward and returns to zero after the query flagged last_query.
// All numbers are signed Q16.16 and the result saturates to 32 bits, flagged by saturated.
// How long one query occupies the block depends on its path: whether the pointer cannot move,
// the scan settles on its first point with an exact hit or a zero, the segment clamps to one
// of its end ordinates or it interpolates; it grows with every table point the pointer steps
// over and with any wait of the previous result in the output register. The 32-step
// restoring divider that forms the interpolation fraction sets most of that, and table points
// are read one at a time through a single registered read port. Items are taken one at a time;
// a finished result waits in the output register while the next transaction is accepted. The
// table is not cleared after reset, so only written entries may be used. Configuration
// registers (0 scale, 1 shift, 2 entries_in_use) are to be written by the user only while the
// block is idle; the block itself does not enforce this.
module shifted_table_linear_interpolator #(
	parameter int TABLE_DEPTH = stli_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [7:0]         entry_index,
	input  logic signed [31:0] entry_x,
	input  logic signed [31:0] entry_y,
	input  logic signed [31:0] query_x,
	input  logic               last_query,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               saturated,
	output logic               last
);

`include "shifted_table_linear_interpolator_defines.svh"

	stli_pkg::cmd_t  cmd;
	stli_pkg::stat_t st;
	logic            busy;

	// The controller sequences the scan, the division and the scaling of one query.
	stli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the table, the registers, the divider and the multipliers.
	stli_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.entry_index (entry_index),
		.entry_x     (entry_x),
		.entry_y     (entry_y),
		.query_x     (query_x),
		.last_query  (last_query),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.saturated   (saturated),
		.last        (last)
	);

	// Input is taken only while the controller is idle.
	assign in_stall = busy;

	// A query keeps the block busy in the following cycle.
	`STLI_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && action, in_stall, "query not held")
	// A result is loaded only when the output register can take it.
	`STLI_ASSERT_NOW(a_emit_free, cmd.emit, st.out_free, "result overwrote waiting output")
	// The pointer is back at zero after the final query of a batch.
	`STLI_ASSERT_NEXT(a_ptr_reset, cmd.emit && st.last_pend, st.ptr_zero, "pointer not reset")

endmodule
